[src/erb_pkg.sv]
package erb_pkg;

	localparam int unsigned TS_W    = 32;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TOTAL_W = 33;
	localparam int unsigned TRIP_W  = 16;
	localparam int unsigned REG_W   = 16;
	localparam int unsigned RATIO_W = 10;
	localparam int unsigned IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		CFG_VALID_WINDOW    = 3'd0,
		CFG_BACKOFF_STEP    = 3'd1,
		CFG_ABSOLUTE_LIMIT  = 3'd2,
		CFG_RATE_FLOOR      = 3'd3,
		CFG_RATIO_PER_MILLE = 3'd4
	} cfg_idx_t;

	localparam logic [REG_W-1:0]   RST_VALID_WINDOW    = 16'd3600;
	localparam logic [REG_W-1:0]   RST_BACKOFF_STEP    = 16'd600;
	localparam logic [REG_W-1:0]   RST_ABSOLUTE_LIMIT  = 16'd12;
	localparam logic [REG_W-1:0]   RST_RATE_FLOOR      = 16'd6;
	localparam logic [RATIO_W-1:0] RST_RATIO_PER_MILLE = 10'd940;

	localparam logic CMD_ADMIT   = 1'b0;
	localparam logic CMD_OUTCOME = 1'b1;

	localparam logic [RATIO_W-1:0] PER_MILLE = 10'd1000;

	typedef struct packed {
		logic [REG_W-1:0]   valid_window;
		logic [REG_W-1:0]   backoff_step;
		logic [REG_W-1:0]   absolute_limit;
		logic [REG_W-1:0]   rate_floor;
		logic [RATIO_W-1:0] ratio_per_mille;
	} cfg_t;

	typedef struct packed {
		logic               command;
		logic [TS_W-1:0]    timestamp;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} head_t;

endpackage

[src/erb_if.sv]
interface erb_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] timestamp;
	logic [31:0] error_count;
	logic [31:0] fatal_count;

	modport source (output valid, command, timestamp, error_count, fatal_count, input ready);
	modport sink (input valid, command, timestamp, error_count, fatal_count, output ready);
endinterface

interface erb_rsp_if;
	logic valid;
	logic ready;
	logic admitted;
	logic breaker_open;
	logic tripped;

	modport source (output valid, admitted, breaker_open, tripped, input ready);
	modport sink (input valid, admitted, breaker_open, tripped, output ready);
endinterface

interface erb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/erb_cfg_regs.sv]
module erb_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	erb_cfg_if.sink       cfg,
	output erb_pkg::cfg_t regs
);

	erb_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.valid_window    <= erb_pkg::RST_VALID_WINDOW;
			regs_q.backoff_step    <= erb_pkg::RST_BACKOFF_STEP;
			regs_q.absolute_limit  <= erb_pkg::RST_ABSOLUTE_LIMIT;
			regs_q.rate_floor      <= erb_pkg::RST_RATE_FLOOR;
			regs_q.ratio_per_mille <= erb_pkg::RST_RATIO_PER_MILLE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				erb_pkg::CFG_VALID_WINDOW:    regs_q.valid_window   <= cfg.data;
				erb_pkg::CFG_BACKOFF_STEP:    regs_q.backoff_step   <= cfg.data;
				erb_pkg::CFG_ABSOLUTE_LIMIT:  regs_q.absolute_limit <= cfg.data;
				erb_pkg::CFG_RATE_FLOOR:      regs_q.rate_floor     <= cfg.data;
				erb_pkg::CFG_RATIO_PER_MILLE: begin
					regs_q.ratio_per_mille <= cfg.data[erb_pkg::RATIO_W-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule

[src/erb_front.sv]
module erb_front (
	input  logic           clk,
	input  logic           arst_n,
	erb_req_if.sink        req,
	input  logic           pop,
	output erb_pkg::head_t head
);

	erb_pkg::entry_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	erb_pkg::entry_t new_entry;

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;

	always_comb begin
		new_entry.command   = req.command;
		new_entry.timestamp = req.timestamp;
		new_entry.total     = {1'b0, req.error_count} + {1'b0, req.fatal_count};
	end

	assign head.valid = (count_q != 2'd0);
	assign head.entry = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/erb_back.sv]
module erb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  erb_pkg::cfg_t  regs,
	input  erb_pkg::head_t head,
	output logic           pop,
	erb_rsp_if.source      rsp
);

	typedef struct packed {
		logic                        open_flag;
		logic [erb_pkg::TS_W-1:0]    trip_time;
		logic [erb_pkg::TRIP_W-1:0]  trip_count;
		logic [erb_pkg::CNT_W-1:0]   risky_calls;
		logic [erb_pkg::CNT_W-1:0]   safe_calls;
		logic [erb_pkg::TOTAL_W-1:0] saved_total;
		logic [erb_pkg::TS_W-1:0]    last_risk_time;
		logic                        risk_seen;
	} state_t;

	state_t st_q;
	state_t st_d;
	logic   out_valid_q;
	logic   admitted_q;
	logic   open_q;
	logic   tripped_q;
	logic   admitted_d;
	logic   tripped_d;

	logic [erb_pkg::TS_W-1:0]    ts;
	logic [erb_pkg::TOTAL_W-1:0] total;
	logic [erb_pkg::TS_W-1:0]    since_risk;
	logic [erb_pkg::TS_W-1:0]    since_trip;
	logic [31:0]                 hold_time;
	logic [erb_pkg::CNT_W-1:0]   risky_inc;
	logic [41:0]                 lhs;
	logic [42:0]                 rhs;
	logic                        trip;

	assign pop = head.valid && (!out_valid_q || rsp.ready);

	assign ts         = head.entry.timestamp;
	assign total      = head.entry.total;
	assign since_risk = ts - st_q.last_risk_time;
	assign since_trip = ts - st_q.trip_time;
	assign hold_time  = {16'd0, regs.backoff_step} * {16'd0, st_q.trip_count};
	assign risky_inc  = (&st_q.risky_calls) ? st_q.risky_calls : st_q.risky_calls + 32'd1;
	assign lhs        = 42'(risky_inc) * 42'(erb_pkg::PER_MILLE);
	assign rhs        = 43'(regs.ratio_per_mille) *
	                    43'({1'b0, risky_inc} + {1'b0, st_q.safe_calls});

	always_comb begin
		if (st_q.safe_calls == '0) begin
			trip = risky_inc > 32'(regs.absolute_limit);
		end else begin
			trip = (risky_inc > 32'(regs.rate_floor)) && ({1'b0, lhs} > rhs);
		end
	end

	always_comb begin
		st_d       = st_q;
		admitted_d = 1'b1;
		tripped_d  = 1'b0;
		if (head.entry.command == erb_pkg::CMD_ADMIT) begin
			if (!st_q.open_flag) begin
				if (st_q.risk_seen && (since_risk > 32'(regs.valid_window))) begin
					st_d = '0;
				end
				st_d.saved_total = total;
			end else if (since_trip > hold_time) begin
				st_d             = '0;
				st_d.trip_count  = st_q.trip_count;
				st_d.saved_total = total;
			end else begin
				admitted_d = 1'b0;
			end
		end else if (!st_q.open_flag) begin
			if (total == st_q.saved_total) begin
				if (!(&st_q.safe_calls)) begin
					st_d.safe_calls = st_q.safe_calls + 32'd1;
				end
			end else begin
				st_d.risky_calls    = risky_inc;
				st_d.last_risk_time = ts;
				st_d.risk_seen      = 1'b1;
				if (trip) begin
					st_d.open_flag = 1'b1;
					st_d.trip_time = ts;
					if (!(&st_q.trip_count)) begin
						st_d.trip_count = st_q.trip_count + 16'd1;
					end
					tripped_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q        <= st_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			admitted_q <= admitted_d;
			open_q     <= st_d.open_flag;
			tripped_q  <= tripped_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.admitted     = admitted_q;
	assign rsp.breaker_open = open_q;
	assign rsp.tripped      = tripped_q;

endmodule

[src/error_rate_circuit_breaker_top.sv]
// Error-rate circuit breaker.
// req carries one request per handshake: command (admission or outcome),
// timestamp, and the caller's cumulative error and fatal counts.
// rsp returns exactly one result per request, in order: admitted,
// breaker_open and tripped.
// cfg writes one of five registers (index 0..4: valid window, backoff
// step, absolute limit, rate floor, per-mille ratio); ready is always high.
// Write registers only while no request is in flight.
// Throughput: one request per cycle while rsp takes results. The front
// adds the counts and pushes into a two-entry queue; the back applies
// the breaker state update combinationally and loads the result
// register, so that update loop sets the rate.
// A request passes the queue, then the result register, on its way to rsp.
// Reset clears the breaker state and loads the register defaults; the
// block takes requests from the first cycle after reset.
// When rsp stalls, the result register holds, the queue fills, and then
// req.ready drops until rsp takes a result.
module error_rate_circuit_breaker_top (
	input  logic      clk,
	input  logic      arst_n,
	erb_req_if.sink   req,
	erb_rsp_if.source rsp,
	erb_cfg_if.sink   cfg
);

	erb_pkg::cfg_t  regs;
	erb_pkg::head_t head;
	logic           pop;

	erb_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	erb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.head   (head)
	);

	erb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.head   (head),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule
